FILE: rtl/bbs_pkg.sv
// Shared constants and controller/datapath interface types for the BBS keystream cipher.
package bbs_pkg;

   localparam int MOD_WIDTH_DEF = 49;
   localparam logic [63:0] MODULUS_RESET = 64'd493104736333267;
   localparam logic [63:0] SEED_RESET = 64'd191;

   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_SEED = 1'b1;

   typedef struct packed {
      logic accept;
      logic red_step;
      logic sq_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bit_last;
      logic sq_last;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/bbs_ctrl.sv
// Sequencing state machine: accept, reduce, eight squarings, result handoff.
module bbs_ctrl
   import bbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_SQUARE = 2'd2;
   localparam logic [1:0] ST_OUTPUT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.bit_last) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
            if (status.bit_last && status.sq_last) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/bbs_dpath.sv
// Datapath: config registers, generator value, bit-serial modular reduce and square, output register.
module bbs_dpath
   import bbs_pkg::*;
#(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [MOD_WIDTH-1:0] csr_wdata,
   input  logic [7:0]           req_data,
   input  logic                 req_restart,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [15:0]          rsp_tdata
);

   localparam int CNT_W = $clog2(MOD_WIDTH);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MOD_WIDTH - 1);

   logic [MOD_WIDTH-1:0] modulus_ff;
   logic [MOD_WIDTH-1:0] seed_ff;
   logic [MOD_WIDTH-1:0] x_ff;
   logic [MOD_WIDTH-1:0] acc_ff;
   logic [MOD_WIDTH-1:0] acc_in;
   logic [CNT_W-1:0]     bit_cnt_ff;
   logic [2:0]           sq_cnt_ff;
   logic [7:0]           data_ff;
   logic [7:0]           key_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;

   logic                 mod_zero;
   logic                 cur_bit;
   logic [MOD_WIDTH:0]   mod_ext;
   logic [MOD_WIDTH:0]   red_sum;
   logic [MOD_WIDTH:0]   dbl_sum;
   logic [MOD_WIDTH:0]   dbl_red;
   logic [MOD_WIDTH:0]   add_sum;
   logic [MOD_WIDTH:0]   add_red;
   logic [2:0]           key_pos;

   assign mod_zero = (modulus_ff == '0);
   assign mod_ext = {1'b0, modulus_ff};
   assign cur_bit = x_ff[bit_cnt_ff];
   assign key_pos = {~sq_cnt_ff[2], sq_cnt_ff[1:0]};

   always_comb begin
      red_sum = {acc_ff, cur_bit};
      if (red_sum >= mod_ext) red_sum = red_sum - mod_ext;

      dbl_sum = {acc_ff, 1'b0};
      dbl_red = (dbl_sum >= mod_ext) ? dbl_sum - mod_ext : dbl_sum;
      add_sum = dbl_red + (cur_bit ? {1'b0, x_ff} : '0);
      add_red = (add_sum >= mod_ext) ? add_sum - mod_ext : add_sum;

      if (mod_zero) begin
         acc_in = '0;
      end else if (cmd.red_step) begin
         acc_in = red_sum[MOD_WIDTH-1:0];
      end else begin
         acc_in = add_red[MOD_WIDTH-1:0];
      end
   end

   assign status.bit_last = (bit_cnt_ff == '0);
   assign status.sq_last = (sq_cnt_ff == 3'd7);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[MOD_WIDTH-1:0];
         seed_ff <= SEED_RESET[MOD_WIDTH-1:0];
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata;
            CSR_SEED:    seed_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= SEED_RESET[MOD_WIDTH-1:0];
      end else if (cmd.accept) begin
         if (req_restart) x_ff <= seed_ff;
      end else if ((cmd.red_step || cmd.sq_step) && status.bit_last) begin
         x_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data;
         acc_ff <= '0;
         bit_cnt_ff <= CNT_TOP;
         sq_cnt_ff <= '0;
      end else if (cmd.red_step || cmd.sq_step) begin
         if (status.bit_last) begin
            acc_ff <= '0;
            bit_cnt_ff <= CNT_TOP;
            if (cmd.sq_step) begin
               key_ff[key_pos] <= acc_in[0];
               sq_cnt_ff <= sq_cnt_ff + 3'd1;
            end
         end else begin
            acc_ff <= acc_in;
            bit_cnt_ff <= bit_cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_data_ff <= {key_ff, data_ff ^ key_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

FILE: rtl/bbs_keystream_xor_cipher.sv
// Top level of the BBS keystream XOR cipher: controller plus datapath.
// One bit-serial modular unit does one reduction pass and eight squarings, one bit a cycle.
// Only one byte is in progress at a time; the next input is taken while a result waits.
// Reset (synchronous, active high): modulus and seed to defaults, generator value to 191,
// result register empty.
module bbs_keystream_xor_cipher
   import bbs_pkg::*;
#(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,  // [7:0] data_byte
   input  logic                 req_tuser,  // [0] restart
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // [7:0] out_byte, [15:8] key_byte
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [MOD_WIDTH-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bbs_dpath #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_data    (req_tdata),
      .req_restart (req_tuser),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: rtl/bbs_checker.sv
// Port-level checker for the BBS keystream cipher and its bind to the top level.
module bbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // busy after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in progress");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared right after input transfer");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind bbs_keystream_xor_cipher bbs_checker u_bbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: verif/bbs_keystream_xor_cipher_checker.sv
// Checker for the BBS keystream cipher: tracks generator state, predicts and compares key and output bytes.
`timescale 1ns / 1ps
module bbs_keystream_xor_cipher_checker
   import bbs_pkg::*;
#(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,  // [7:0] data_byte
   input  logic                 req_tuser,  // [0] restart
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [15:0]          rsp_tdata,  // [7:0] out_byte, [15:8] key_byte
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [MOD_WIDTH-1:0] csr_wdata,
   output int unsigned          fail_count,
   output int unsigned          outstanding
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] key_byte;
   } cipher_result_type;

   cipher_result_type      expected_ciphers[$];
   cipher_result_type      predicted;
   cipher_result_type      observed;
   logic [MOD_WIDTH-1:0]   modulus_reg;
   logic [MOD_WIDTH-1:0]   seed_reg;
   logic [MOD_WIDTH-1:0]   bbs_state;
   logic [MOD_WIDTH-1:0]   x_val;
   logic [7:0]             key_bits;

   // x*x mod m, zero for a zero modulus
   function automatic logic [MOD_WIDTH-1:0] square_residue(input logic [MOD_WIDTH-1:0] a,
                                                           input logic [MOD_WIDTH-1:0] m);
      logic [2*MOD_WIDTH-1:0] base;
      logic [2*MOD_WIDTH-1:0] prod;
      if (m == '0) return '0;
      base = {{MOD_WIDTH{1'b0}}, a % m};
      prod = base * base;
      prod = prod % {{MOD_WIDTH{1'b0}}, m};
      return prod[MOD_WIDTH-1:0];
   endfunction

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         modulus_reg = MODULUS_RESET[MOD_WIDTH-1:0];
         seed_reg = SEED_RESET[MOD_WIDTH-1:0];
         bbs_state = SEED_RESET[MOD_WIDTH-1:0];
         expected_ciphers.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MODULUS) modulus_reg = csr_wdata;
            else seed_reg = csr_wdata;
         end

         if (req_tvalid && req_tready) begin
            x_val = req_tuser ? seed_reg : bbs_state;
            key_bits = '0;
            for (int k = 0; k < 8; k++) begin
               x_val = square_residue(x_val, modulus_reg);
               if (k < 4) key_bits[4 + k] = x_val[0];
               else key_bits[k - 4] = x_val[0];
            end
            bbs_state = x_val;
            predicted.key_byte = key_bits;
            predicted.out_byte = req_tdata ^ key_bits;
            expected_ciphers.push_back(predicted);
         end

         if (rsp_tvalid && rsp_tready) begin
            observed = {rsp_tdata[7:0], rsp_tdata[15:8]};
            if (expected_ciphers.size() == 0) begin
               $error("rsp transfer with nothing expected: out_byte %02h key_byte %02h",
                      observed.out_byte, observed.key_byte);
               fail_count++;
            end else begin
               predicted = expected_ciphers.pop_front();
               if (observed.out_byte !== predicted.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         predicted.out_byte, observed.out_byte);
                  fail_count++;
               end
               if (observed.key_byte !== predicted.key_byte) begin
                  $error("key_byte mismatch: expected %02h, actual %02h",
                         predicted.key_byte, observed.key_byte);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_ciphers.size();
   end

endmodule

FILE: verif/bbs_keystream_xor_cipher_tb.sv
// Testbench top for the BBS keystream cipher: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module bbs_keystream_xor_cipher_tb;
   import bbs_pkg::*;

   localparam int MW = MOD_WIDTH_DEF;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 500;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS = 100;
   localparam logic [MW-1:0] VALUE_MAX = '1;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;
   logic          csr_we = 1'b0;
   logic          csr_index = CSR_MODULUS;
   logic [MW-1:0] csr_wdata = '0;

   int unsigned   fail_count;
   int unsigned   outstanding;
   int unsigned   stall_cycles = 0;
   int unsigned   bytes_sent = 0;
   int unsigned   restarts_sent = 0;
   int unsigned   reg_writes = 0;
   logic          steady = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bbs_keystream_xor_cipher #(.MOD_WIDTH(MW)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bbs_keystream_xor_cipher_checker #(.MOD_WIDTH(MW)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", stall_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [MW-1:0] rand_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[MW-1:0];
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic restart);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= restart;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (restart) restarts_sent++;
   endtask

   // stop sending and wait until every predicted result has been seen
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic idx, input logic [MW-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      reg_writes++;
   endtask

   function automatic logic [MW-1:0] pick_modulus();
      case ($urandom_range(9))
         0: return MODULUS_RESET[MW-1:0];
         1: return VALUE_MAX;
         2: return MW'($urandom_range(2));
         3: return MW'($urandom_range(1000, 3));
         4: return rand_value() | MW'(1);
         default: return rand_value();
      endcase
   endfunction

   function automatic logic [MW-1:0] pick_seed(input logic [MW-1:0] modulus);
      case ($urandom_range(7))
         0: return '0;
         1: return VALUE_MAX;
         2: return modulus + MW'($urandom_range(1000));
         3: return MW'($urandom_range(5000));
         default: return rand_value();
      endcase
   endfunction

   initial begin
      logic [MW-1:0] modulus;
      logic [MW-1:0] seed;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults, generator starts at 191
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      // zero modulus
      drain_results();
      write_reg(CSR_MODULUS, '0);
      send_byte(8'h3C, 1'b1);
      send_byte(8'hC3, 1'b0);
      // modulus of one
      drain_results();
      write_reg(CSR_MODULUS, MW'(1));
      send_byte(8'h81, 1'b1);
      send_byte(8'h7E, 1'b0);
      // seed above a tiny modulus
      drain_results();
      write_reg(CSR_MODULUS, MW'(2));
      write_reg(CSR_SEED, MW'(3));
      send_byte(8'h55, 1'b1);
      send_byte(8'hAA, 1'b0);
      // seed equal to the largest modulus
      drain_results();
      write_reg(CSR_MODULUS, VALUE_MAX);
      write_reg(CSR_SEED, VALUE_MAX);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      // largest seed over a small modulus
      drain_results();
      write_reg(CSR_MODULUS, MW'(7));
      write_reg(CSR_SEED, VALUE_MAX);
      send_byte(8'h0F, 1'b1);
      send_byte(8'hF0, 1'b0);
      // zero seed
      drain_results();
      write_reg(CSR_SEED, '0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);
      drain_results();
      write_reg(CSR_MODULUS, VALUE_MAX - MW'(2));
      write_reg(CSR_SEED, MW'(2));
      send_byte(8'h12, 1'b1);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      drain_results();
      write_reg(CSR_MODULUS, MODULUS_RESET[MW-1:0]);
      write_reg(CSR_SEED, SEED_RESET[MW-1:0]);
      send_byte(8'hC0, 1'b1);
      send_byte(8'h03, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         steady = (p == RANDOM_PHASES / 2);
         modulus = pick_modulus();
         seed = pick_seed(modulus);
         if ($urandom_range(1)) begin
            write_reg(CSR_SEED, seed);
            write_reg(CSR_MODULUS, modulus);
         end else begin
            write_reg(CSR_MODULUS, modulus);
            write_reg(CSR_SEED, seed);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_byte(8'($urandom_range(255)),
                      (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 4));
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes (%0d with generator restart) across %0d register writes,",
               bytes_sent, restarts_sent, reg_writes);
      $display("covering zero, unit, tiny, default, random and full-width moduli and seeds.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/bbs_pkg.sv
rtl/bbs_ctrl.sv
rtl/bbs_dpath.sv
rtl/bbs_keystream_xor_cipher.sv
rtl/bbs_checker.sv
verif/bbs_keystream_xor_cipher_checker.sv
verif/bbs_keystream_xor_cipher_tb.sv
